// ===== rtl/core/wsd_pkg.sv =====
package wsd_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [6:0]  LEN_CODE_16   = 7'd126;
    localparam logic [6:0]  LEN_CODE_64   = 7'd127;
    localparam logic [15:0] PING_LEN_MAX  = 16'd125;

    localparam logic [3:0] OPC_CONT   = 4'h0;
    localparam logic [3:0] OPC_TEXT   = 4'h1;
    localparam logic [3:0] OPC_BINARY = 4'h2;
    localparam logic [3:0] OPC_CLOSE  = 4'h8;
    localparam logic [3:0] OPC_PING   = 4'h9;
    localparam logic [3:0] OPC_PONG   = 4'hA;

    typedef enum logic [2:0] {
        KIND_DATA       = 3'd0,
        KIND_PING       = 3'd1,
        KIND_EMPTY_DATA = 3'd2,
        KIND_EMPTY_PING = 3'd3,
        KIND_STOP       = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_NONE   = 3'd0,
        ST_NORMAL = 3'd1,
        ST_PROTO  = 3'd2,
        ST_BIG    = 3'd3,
        ST_TYPE   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PH_FLAGS  = 3'd0,
        PH_LEN    = 3'd1,
        PH_EXT_HI = 3'd2,
        PH_EXT_LO = 3'd3,
        PH_KEY0   = 3'd4,
        PH_KEY1   = 3'd5,
        PH_KEY2   = 3'd6,
        PH_KEY3   = 3'd7
    } phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [7:0] key;
        logic       last;
        logic       mend;
        status_t    status;
    } cmd_t;

endpackage

// ===== rtl/core/wsd_front.sv =====
module wsd_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          fire,
    input  logic [7:0]    data_byte,
    output logic          push,
    output wsd_pkg::cmd_t cmd
);
    import wsd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        in_payload_reg, in_payload_next;
    logic        stopped_reg, stopped_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opc_reg, opc_next;
    logic [15:0] len_reg, len_next;
    logic [31:0] key_reg, key_next;
    logic [15:0] count_reg, count_next;

    logic [15:0] count_inc;
    logic        payload_last;
    logic [7:0]  key_byte;

    assign count_inc    = count_reg + 16'd1;
    assign payload_last = (count_inc == len_reg);

    always_comb begin
        case (count_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // parser state
    always_comb begin
        phase_next      = phase_reg;
        in_payload_next = in_payload_reg;
        stopped_next    = stopped_reg;
        fin_next        = fin_reg;
        opc_next        = opc_reg;
        len_next        = len_reg;
        key_next        = key_reg;
        count_next      = count_reg;
        if (fire && !stopped_reg) begin
            if (in_payload_reg) begin
                count_next = count_inc;
                if (payload_last) begin
                    in_payload_next = 1'b0;
                    phase_next      = PH_FLAGS;
                end
            end else begin
                case (phase_reg)
                    PH_FLAGS: begin
                        fin_next = data_byte[7];
                        opc_next = data_byte[3:0];
                        if (data_byte[6:4] != 3'd0) begin
                            stopped_next = 1'b1;
                        end else begin
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        if (!data_byte[7] || data_byte[6:0] == LEN_CODE_64) begin
                            stopped_next = 1'b1;
                        end else begin
                            key_next = 32'd0;
                            if (data_byte[6:0] == LEN_CODE_16) begin
                                len_next   = 16'd0;
                                phase_next = PH_EXT_HI;
                            end else begin
                                len_next   = {9'd0, data_byte[6:0]};
                                phase_next = PH_KEY0;
                            end
                        end
                    end
                    PH_EXT_HI: begin
                        len_next   = {data_byte, 8'h00};
                        phase_next = PH_EXT_LO;
                    end
                    PH_EXT_LO: begin
                        len_next   = {len_reg[15:8], data_byte};
                        phase_next = PH_KEY0;
                    end
                    PH_KEY0: begin
                        key_next   = {key_reg[23:0], data_byte};
                        phase_next = PH_KEY1;
                    end
                    PH_KEY1: begin
                        key_next   = {key_reg[23:0], data_byte};
                        phase_next = PH_KEY2;
                    end
                    PH_KEY2: begin
                        key_next   = {key_reg[23:0], data_byte};
                        phase_next = PH_KEY3;
                    end
                    PH_KEY3: begin
                        key_next   = {key_reg[23:0], data_byte};
                        phase_next = PH_FLAGS;
                        count_next = 16'd0;
                        case (opc_reg)
                            OPC_PING: begin
                                if (len_reg > PING_LEN_MAX) begin
                                    stopped_next = 1'b1;
                                end else begin
                                    in_payload_next = (len_reg != 16'd0);
                                end
                            end
                            OPC_PONG, OPC_CONT, OPC_BINARY: begin
                                in_payload_next = (len_reg != 16'd0);
                            end
                            default: begin
                                stopped_next = 1'b1;
                            end
                        endcase
                    end
                    default: begin
                        phase_next = PH_FLAGS;
                    end
                endcase
            end
        end
    end

    // request to the back end
    always_comb begin
        push       = 1'b0;
        cmd.kind   = KIND_STOP;
        cmd.data   = 8'd0;
        cmd.key    = 8'd0;
        cmd.last   = 1'b0;
        cmd.mend   = 1'b0;
        cmd.status = ST_NONE;
        if (fire && !stopped_reg) begin
            if (in_payload_reg) begin
                push     = (opc_reg != OPC_PONG);
                cmd.kind = (opc_reg == OPC_PING) ? KIND_PING : KIND_DATA;
                cmd.data = data_byte;
                cmd.key  = key_byte;
                cmd.last = payload_last;
                cmd.mend = payload_last && fin_reg;
            end else begin
                case (phase_reg)
                    PH_FLAGS: begin
                        if (data_byte[6:4] != 3'd0) begin
                            push       = 1'b1;
                            cmd.status = ST_PROTO;
                        end
                    end
                    PH_LEN: begin
                        if (!data_byte[7]) begin
                            push       = 1'b1;
                            cmd.status = ST_PROTO;
                        end else if (data_byte[6:0] == LEN_CODE_64) begin
                            push       = 1'b1;
                            cmd.status = ST_BIG;
                        end
                    end
                    PH_KEY3: begin
                        case (opc_reg)
                            OPC_TEXT: begin
                                push       = 1'b1;
                                cmd.status = ST_TYPE;
                            end
                            OPC_CLOSE: begin
                                push       = 1'b1;
                                cmd.status = ST_NORMAL;
                            end
                            OPC_PONG: begin
                                push = 1'b0;
                            end
                            OPC_PING: begin
                                if (len_reg > PING_LEN_MAX) begin
                                    push       = 1'b1;
                                    cmd.status = ST_BIG;
                                end else if (len_reg == 16'd0) begin
                                    push     = 1'b1;
                                    cmd.kind = KIND_EMPTY_PING;
                                    cmd.last = 1'b1;
                                    cmd.mend = fin_reg;
                                end
                            end
                            OPC_CONT, OPC_BINARY: begin
                                if (len_reg == 16'd0) begin
                                    push     = 1'b1;
                                    cmd.kind = KIND_EMPTY_DATA;
                                    cmd.last = 1'b1;
                                    cmd.mend = fin_reg;
                                end
                            end
                            default: begin
                                push       = 1'b1;
                                cmd.status = ST_PROTO;
                            end
                        endcase
                    end
                    default: begin
                        push = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_FLAGS;
            in_payload_reg <= 1'b0;
            stopped_reg    <= 1'b0;
            fin_reg        <= 1'b0;
            opc_reg        <= 4'd0;
            len_reg        <= 16'd0;
            key_reg        <= 32'd0;
            count_reg      <= 16'd0;
        end else begin
            phase_reg      <= phase_next;
            in_payload_reg <= in_payload_next;
            stopped_reg    <= stopped_next;
            fin_reg        <= fin_next;
            opc_reg        <= opc_next;
            len_reg        <= len_next;
            key_reg        <= key_next;
            count_reg      <= count_next;
        end
    end

endmodule

// ===== rtl/core/wsd_queue.sv =====
module wsd_queue #(
    parameter int DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  wsd_pkg::cmd_t wr_cmd,
    output logic          full,
    input  logic          pop,
    output logic          rd_valid,
    output wsd_pkg::cmd_t rd_cmd
);
    import wsd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full     = (cnt_reg == FULL_CNT);
    assign rd_valid = (cnt_reg != '0);
    assign rd_cmd   = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/wsd_back.sv =====
module wsd_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  wsd_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [15:0]   m_tdata,
    output logic [3:0]    m_tuser,
    output logic          m_tlast
);
    import wsd_pkg::*;

    logic       valid_reg, valid_next;
    kind_t      kind_reg;
    logic [7:0] payload_reg;
    logic       last_reg;
    logic       mend_reg;
    status_t    status_reg;

    assign q_pop = q_valid && (!valid_reg || m_tready);

    always_comb begin
        valid_next = valid_reg;
        if (q_pop) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // unmask on load
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            kind_reg    <= q_cmd.kind;
            payload_reg <= q_cmd.data ^ q_cmd.key;
            last_reg    <= q_cmd.last;
            mend_reg    <= q_cmd.mend;
            status_reg  <= q_cmd.status;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, status_reg, payload_reg};
    assign m_tuser  = {mend_reg, kind_reg};
    assign m_tlast  = last_reg;

endmodule

// ===== rtl/core/websocket_frame_deframer.sv =====
// Client-to-server WebSocket deframer: one stream byte is taken per cycle while the
// request queue (QUEUE_DEPTH entries) is not full and yields at most one result: an
// unmasked payload byte, an empty-frame marker or a stop event. The header parser in
// front never waits on the output except through a full queue, so with the master
// side ready the sustained rate is one byte per cycle. A result is written to the queue
// at the accepting edge and loaded into the output register when it is empty or
// m_tready is high. After a stop event every byte is taken and dropped until reset.
module websocket_frame_deframer #(
    parameter int QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // payload[7:0], status[10:8], zero[15:11]
    output logic [3:0]  m_tuser,   // kind[2:0], message_end[3]
    output logic        m_tlast    // frame_last
);
    import wsd_pkg::*;

    logic fire;
    logic push;
    cmd_t front_cmd;
    logic q_full;
    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    assign s_tready = !q_full;
    assign fire     = s_tvalid && s_tready;

    wsd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .data_byte (s_tdata),
        .push      (push),
        .cmd       (front_cmd)
    );

    wsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .wr_cmd   (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_cmd   (q_cmd)
    );

    wsd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_stop_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2:0] == KIND_STOP)
            |-> (m_tdata[10:8] != ST_NONE && !m_tlast && !m_tuser[3] && m_tdata[7:0] == 8'd0))
        else $error("stop event with bad fields");

    a_status_only_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2:0] != KIND_STOP) |-> (m_tdata[10:8] == ST_NONE))
        else $error("status on non-stop result");

    a_mend_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[3]) |-> m_tlast)
        else $error("message end without frame last");

    a_push_space: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("request pushed into full queue");

endmodule

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wsd_pkg::*;

    typedef struct {
        kind_t      kind;
        logic [7:0] payload;
        logic       frame_last;
        logic       message_end;
        status_t    status;
    } deframed_t;

    typedef struct {
        logic [7:0] data;
        bit         drain;
    } stream_byte_t;

    typedef enum int {
        BRK_RSV,
        BRK_NOMASK,
        BRK_LEN64,
        BRK_TEXT,
        BRK_CLOSE,
        BRK_BIGPING,
        BRK_OPCODE
    } break_t;

    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    websocket_frame_deframer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    stream_byte_t pending_bytes[$];
    deframed_t    expected_results[$];
    deframed_t    want;
    int           error_count = 0;
    int           results_seen = 0;
    int           stall_cycles = 0;
    logic         s_fire = 1'b0;

    // parser state of the predictor
    phase_t      hdr_phase = PH_FLAGS;
    logic        in_body = 1'b0;
    logic        halted = 1'b0;
    logic        fin_bit = 1'b0;
    logic [3:0]  frame_opc = OPC_CONT;
    logic [15:0] frame_len = 16'h0000;
    logic [31:0] mask_word = 32'h0;
    logic [15:0] body_count = 16'h0000;

    function automatic void push_result(kind_t k, logic [7:0] p, logic fl, logic me,
                                        status_t st);
        deframed_t r;
        r.kind = k;
        r.payload = p;
        r.frame_last = fl;
        r.message_end = me;
        r.status = st;
        expected_results.push_back(r);
    endfunction

    function automatic void halt_parser(status_t st);
        halted = 1'b1;
        in_body = 1'b0;
        push_result(KIND_STOP, 8'h00, 1'b0, 1'b0, st);
    endfunction

    function automatic void deframe_byte(logic [7:0] b);
        int         sh;
        logic [7:0] plain;
        logic       done;
        if (halted)
            return;
        if (in_body) begin
            sh = 24 - 8 * int'(body_count[1:0]);
            plain = b ^ mask_word[sh +: 8];
            body_count = body_count + 16'd1;
            done = (body_count == frame_len);
            if (done) begin
                in_body = 1'b0;
                hdr_phase = PH_FLAGS;
            end
            if (frame_opc != OPC_PONG)
                push_result(frame_opc == OPC_PING ? KIND_PING : KIND_DATA, plain, done,
                            done && fin_bit, ST_NONE);
            return;
        end
        case (hdr_phase)
            PH_FLAGS: begin
                fin_bit = b[7];
                frame_opc = b[3:0];
                if (b[6:4] != 3'b000)
                    halt_parser(ST_PROTO);
                else
                    hdr_phase = PH_LEN;
            end
            PH_LEN: begin
                if (!b[7]) begin
                    halt_parser(ST_PROTO);
                end else if (b[6:0] == LEN_CODE_64) begin
                    halt_parser(ST_BIG);
                end else begin
                    mask_word = 32'h0;
                    if (b[6:0] == LEN_CODE_16) begin
                        frame_len = 16'h0000;
                        hdr_phase = PH_EXT_HI;
                    end else begin
                        frame_len = {9'b0, b[6:0]};
                        hdr_phase = PH_KEY0;
                    end
                end
            end
            PH_EXT_HI: begin
                frame_len = {b, 8'h00};
                hdr_phase = PH_EXT_LO;
            end
            PH_EXT_LO: begin
                frame_len = frame_len | {8'h00, b};
                hdr_phase = PH_KEY0;
            end
            PH_KEY0, PH_KEY1, PH_KEY2: begin
                mask_word = {mask_word[23:0], b};
                hdr_phase = phase_t'(hdr_phase + 3'd1);
            end
            default: begin
                // header end, opcode decides
                mask_word = {mask_word[23:0], b};
                hdr_phase = PH_FLAGS;
                body_count = 16'h0000;
                case (frame_opc)
                    OPC_TEXT:  halt_parser(ST_TYPE);
                    OPC_CLOSE: halt_parser(ST_NORMAL);
                    OPC_PONG: begin
                        if (frame_len != 16'h0000)
                            in_body = 1'b1;
                    end
                    OPC_PING: begin
                        if (frame_len > PING_LEN_MAX)
                            halt_parser(ST_BIG);
                        else if (frame_len == 16'h0000)
                            push_result(KIND_EMPTY_PING, 8'h00, 1'b1, fin_bit, ST_NONE);
                        else
                            in_body = 1'b1;
                    end
                    OPC_CONT, OPC_BINARY: begin
                        if (frame_len == 16'h0000)
                            push_result(KIND_EMPTY_DATA, 8'h00, 1'b1, fin_bit, ST_NONE);
                        else
                            in_body = 1'b1;
                    end
                    default: halt_parser(ST_PROTO);
                endcase
            end
        endcase
    endfunction

    // request stream building
    function automatic logic [7:0] random_byte();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [31:0] random_key();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h0000_0000;
        if (r == 1)
            return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    function automatic void push_byte(logic [7:0] b, bit d);
        stream_byte_t e;
        e.data = b;
        e.drain = d;
        pending_bytes.push_back(e);
    endfunction

    function automatic void send_header(bit fin, logic [2:0] rsv, logic [3:0] opc, bit masked,
                                        logic [6:0] code, logic [15:0] ext_len,
                                        logic [31:0] mkey, bit d);
        push_byte({fin, rsv, opc}, d);
        push_byte({masked, code}, 1'b0);
        if (code == LEN_CODE_16) begin
            push_byte(ext_len[15:8], 1'b0);
            push_byte(ext_len[7:0], 1'b0);
        end
        push_byte(mkey[31:24], 1'b0);
        push_byte(mkey[23:16], 1'b0);
        push_byte(mkey[15:8], 1'b0);
        push_byte(mkey[7:0], 1'b0);
    endfunction

    function automatic void send_frame(bit fin, logic [3:0] opc, int len, bit ext,
                                       logic [31:0] mkey, bit d);
        send_header(fin, 3'b000, opc, 1'b1, ext ? LEN_CODE_16 : 7'(len), 16'(len), mkey, d);
        repeat (len) push_byte(random_byte(), 1'b0);
    endfunction

    function automatic int idle_len(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // request driver
    int gap_left = 0;
    bit tx_quiet = 1'b0;

    always @(negedge aclk) begin
        if ($urandom_range(0, 63) == 0)
            tx_quiet = !tx_quiet;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0 &&
                         !(pending_bytes[0].drain && expected_results.size() > 0)) begin
                s_tdata <= pending_bytes[0].data;
                s_tvalid <= 1'b1;
                void'(pending_bytes.pop_front());
                gap_left = idle_len(tx_quiet);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver
    int  hold_left = 0;
    bit  rx_quiet = 1'b0;
    bit  long_hold_done = 1'b0;
    int  n;

    always @(negedge aclk) begin
        if ($urandom_range(0, 63) == 0)
            rx_quiet = !rx_quiet;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!long_hold_done && results_seen >= 40) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else begin
            n = idle_len(rx_quiet);
            if (n == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                hold_left = n - 1;
            end
        end
    end

    // monitor, checker and watchdog
    always @(posedge aclk) begin
        s_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            deframe_byte(s_tdata);
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("unexpected result: kind %0d payload %0h status %0d",
                       m_tuser[2:0], m_tdata[7:0], m_tdata[10:8]);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tuser[2:0] !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_tuser[2:0]);
                    error_count++;
                end
                if (m_tdata[7:0] !== want.payload) begin
                    $error("payload: expected %0h, got %0h", want.payload, m_tdata[7:0]);
                    error_count++;
                end
                if (m_tlast !== want.frame_last) begin
                    $error("frame_last: expected %0d, got %0d", want.frame_last, m_tlast);
                    error_count++;
                end
                if (m_tuser[3] !== want.message_end) begin
                    $error("message_end: expected %0d, got %0d", want.message_end, m_tuser[3]);
                    error_count++;
                end
                if (m_tdata[10:8] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[10:8]);
                    error_count++;
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int         r;
        int         len;
        bit         ext;
        bit         mid_drain;
        logic [3:0] opc;
        break_t     brk;

        // directed frames
        send_frame(1'b0, OPC_BINARY, 0, 1'b0, 32'hFFFF_FFFF, 1'b0);
        send_frame(1'b1, OPC_PING, 0, 1'b1, 32'h0000_0000, 1'b0);
        send_frame(1'b1, OPC_PING, 1, 1'b0, 32'h0000_0000, 1'b0);
        send_frame(1'b1, OPC_PONG, 1, 1'b0, random_key(), 1'b0);

        // well-formed random frames
        mid_drain = 1'b0;
        while (pending_bytes.size() < 900) begin
            r = $urandom_range(0, 99);
            opc = (r < 40) ? OPC_BINARY : (r < 70) ? OPC_CONT : (r < 90) ? OPC_PING : OPC_PONG;
            r = $urandom_range(0, 99);
            ext = 1'b0;
            if (r < 15) begin
                len = 0;
            end else if (r < 55) begin
                len = $urandom_range(1, 12);
            end else if (r < 85) begin
                len = $urandom_range(13, 125);
            end else begin
                ext = 1'b1;
                len = (opc == OPC_PING) ? $urandom_range(0, 125) : $urandom_range(0, 400);
            end
            send_frame(1'($urandom_range(0, 1)), opc, len, ext, random_key(),
                       !mid_drain && pending_bytes.size() > 500);
            if (pending_bytes.size() > 500)
                mid_drain = 1'b1;
        end

        // one broken frame ends the stream, trailing bytes are dropped
        brk = break_t'($urandom_range(BRK_RSV, BRK_OPCODE));
        case (brk)
            BRK_RSV:
                send_header(1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)), OPC_BINARY,
                            1'b1, 7'd4, 16'h0, random_key(), 1'b1);
            BRK_NOMASK:
                send_header(1'b1, 3'b000, OPC_BINARY, 1'b0, 7'($urandom_range(0, 127)),
                            16'h0, random_key(), 1'b1);
            BRK_LEN64:
                send_header(1'b1, 3'b000, OPC_BINARY, 1'b1, LEN_CODE_64, 16'h0,
                            random_key(), 1'b1);
            BRK_TEXT:
                send_header(1'b1, 3'b000, OPC_TEXT, 1'b1, 7'($urandom_range(0, 20)), 16'h0,
                            random_key(), 1'b1);
            BRK_CLOSE:
                send_header(1'b1, 3'b000, OPC_CLOSE, 1'b1, 7'($urandom_range(0, 20)), 16'h0,
                            random_key(), 1'b1);
            BRK_BIGPING:
                send_header(1'b1, 3'b000, OPC_PING, 1'b1, LEN_CODE_16,
                            16'($urandom_range(126, 400)), random_key(), 1'b1);
            default: begin
                opc = $urandom_range(0, 1) ? 4'($urandom_range(3, 7))
                                           : 4'($urandom_range(11, 15));
                send_header(1'b1, 3'b000, opc, 1'b1, 7'($urandom_range(0, 20)), 16'h0,
                            random_key(), 1'b1);
            end
        endcase
        repeat (8) push_byte(random_byte(), 1'b0);

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_bytes.size() > 0 || s_tvalid)
            @(posedge aclk);
        while (expected_results.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
